### src/dtfs_pkg.sv
`default_nettype none

package dtfs_pkg;

   // Widths of the fixed payload fields.
   localparam int CMD_W   = 4;
   localparam int IDX_W   = 6;
   localparam int LANE_W  = 3;
   localparam int VAL_W   = 32;
   localparam int DATA_W  = 64;
   localparam int ST_W    = 2;
   localparam int BC_W    = 9;
   localparam int CNT_W   = 7;

   // Packed stream word widths, rounded up to whole bytes.
   localparam int REQ_TDATA_W = 80;
   localparam int RSP_TDATA_W = 56;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_WORD  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_PAIR  = 4'd1;
   localparam logic [CMD_W-1:0] CMD_BYTE  = 4'd2;
   localparam logic [CMD_W-1:0] CMD_HALF  = 4'd3;
   localparam logic [CMD_W-1:0] CMD_SETF  = 4'd4;
   localparam logic [CMD_W-1:0] CMD_CLRF  = 4'd5;
   localparam logic [CMD_W-1:0] CMD_READ  = 4'd6;
   localparam logic [CMD_W-1:0] CMD_CLRM  = 4'd7;
   localparam logic [CMD_W-1:0] CMD_DUMP  = 4'd8;

   // Status codes.
   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [ST_W-1:0] ST_BAD_LANE  = 2'd2;

   // Configuration register indexes.
   localparam logic [0:0] CSR_FIELDS_IN_USE = 1'b0;
   localparam logic [0:0] CSR_IN_WORLD      = 1'b1;

   localparam logic [CNT_W-1:0] FIELDS_RESET = 7'd64;
   localparam logic [BC_W-1:0]  ENTRY_BYTES  = 9'd6;

   // One result word.
   typedef struct packed {
      logic [ST_W-1:0]  status;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
      logic             mark;
      logic             enlist;
      logic             delist;
      logic             pending;
      logic             entry_valid;
      logic [BC_W-1:0]  byte_count;
      logic             last;
   } rsp_type;

endpackage

`default_nettype wire

### src/dtfs_ram.sv
`default_nettype none

module dtfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port; read data holds when idle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/dtfs_rsp_reg.sv
`default_nettype none

module dtfs_rsp_reg
   import dtfs_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire rsp_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output rsp_type      out_data
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // The slot takes a new word when it is empty or being drained.
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

### src/dtfs_seq.sv
`default_nettype none

module dtfs_seq
   import dtfs_pkg::*;
#(
   parameter int MAX_FIELDS = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [CNT_W-1:0]              cnt,
   input  wire logic                          in_world,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic [CMD_W-1:0]              in_cmd,
   input  wire logic [IDX_W-1:0]              in_idx,
   input  wire logic [LANE_W-1:0]             in_lane,
   input  wire logic [DATA_W-1:0]             in_data,
   input  wire logic                          in_drop,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output rsp_type                            out_data,
   output logic                               ram_we,
   output logic [$clog2(MAX_FIELDS)-1:0]      ram_waddr,
   output logic [VAL_W-1:0]                   ram_wdata,
   output logic                               ram_re,
   output logic [$clog2(MAX_FIELDS)-1:0]      ram_raddr,
   input  wire logic [VAL_W-1:0]              ram_rdata
);

   localparam int AW = $clog2(MAX_FIELDS);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RD0  = 6'b000010,
      S_RD1  = 6'b000100,
      S_WR1  = 6'b001000,
      S_RSP  = 6'b010000,
      S_DCHK = 6'b100000
   } seq_state_type;

   seq_state_type          state_ff, state_in;
   logic                   pending_ff, pending_in;
   logic [MAX_FIELDS-1:0]  valid_ff, valid_in;
   logic [MAX_FIELDS-1:0]  chg_ff, chg_in;
   logic                   held_ff, held_in;
   rsp_type                res_ff, res_in;
   logic [CMD_W-1:0]       cmd_ff, cmd_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [LANE_W-1:0]      lane_ff, lane_in;
   logic [DATA_W-1:0]      data_ff, data_in;
   logic [VAL_W-1:0]       old_ff, old_in;
   logic [AW-1:0]          addr_ff, addr_in;

   logic [AW-1:0]          idx_a, idx_b;
   logic [VAL_W-1:0]       rd_val;
   logic [VAL_W-1:0]       new_val;
   logic                   changed;
   logic                   enl;
   logic                   idx_bad;
   logic                   lane_bad;
   logic                   last_addr;

   assign idx_a = idx_ff[AW-1:0];
   assign idx_b = idx_ff[AW-1:0] + 1'b1;

   // Entries never written read as zero.
   always_comb begin
      rd_val = '0;
      if (state_ff == S_DCHK) begin
         if (valid_ff[addr_ff]) begin
            rd_val = ram_rdata;
         end
      end else if (state_ff == S_RD1) begin
         if (valid_ff[idx_b]) begin
            rd_val = ram_rdata;
         end
      end else if (valid_ff[idx_a]) begin
         rd_val = ram_rdata;
      end
   end

   // New field value for the single-entry commands.
   always_comb begin
      new_val = rd_val;
      case (cmd_ff)
         CMD_WORD: new_val = data_ff[VAL_W-1:0];
         CMD_BYTE: new_val[{lane_ff[1:0], 3'b000} +: 8] = data_ff[7:0];
         CMD_HALF: new_val[{lane_ff[0], 4'b0000} +: 16] = data_ff[15:0];
         CMD_SETF: new_val = rd_val | data_ff[VAL_W-1:0];
         CMD_CLRF: new_val = rd_val & ~data_ff[VAL_W-1:0];
         default:  new_val = rd_val;
      endcase
   end

   // Request checks, made as the word is taken.
   assign idx_bad = (in_cmd == CMD_PAIR) ? ({1'b0, in_idx} + 7'd1 >= cnt)
                                         : ({1'b0, in_idx} >= cnt);
   assign lane_bad = ((in_cmd == CMD_BYTE) && (in_lane > 3'd3)) ||
                     ((in_cmd == CMD_HALF) && (in_lane > 3'd1));

   assign last_addr = (CNT_W'(addr_ff) + 7'd1) == cnt;

   // Sequencer.
   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      valid_in   = valid_ff;
      chg_in     = chg_ff;
      held_in    = held_ff;
      res_in     = res_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      lane_in    = lane_ff;
      data_in    = data_ff;
      old_in     = old_ff;
      addr_in    = addr_ff;
      in_ready   = 1'b0;
      out_valid  = 1'b0;
      ram_we     = 1'b0;
      ram_waddr  = idx_a;
      ram_wdata  = new_val;
      ram_re     = 1'b0;
      ram_raddr  = idx_a;
      changed    = 1'b0;
      enl        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
         end

         // First read data is here; single-entry commands finish now.
         S_RD0: begin
            if (cmd_ff == CMD_PAIR) begin
               old_in    = rd_val;
               ram_re    = 1'b1;
               ram_raddr = idx_b;
               state_in  = S_RD1;
            end else begin
               changed = (cmd_ff != CMD_READ) && (new_val != rd_val);
               enl     = changed && in_world && !pending_ff;
               ram_we  = changed;
               res_in         = '0;
               res_in.status  = ST_OK;
               res_in.index   = idx_ff;
               res_in.value   = new_val;
               res_in.mark    = chg_ff[idx_a] | changed;
               res_in.enlist  = enl;
               res_in.pending = pending_ff | enl;
               pending_in     = pending_ff | enl;
               state_in       = S_RSP;
            end
         end

         // Pair: second read data is here; write the low word now if the pair changes.
         S_RD1: begin
            changed = (old_ff != data_ff[VAL_W-1:0]) ||
                      (rd_val != data_ff[DATA_W-1:VAL_W]);
            enl       = changed && in_world && !pending_ff;
            ram_we    = changed;
            ram_wdata = data_ff[VAL_W-1:0];
            res_in         = '0;
            res_in.status  = ST_OK;
            res_in.index   = idx_ff;
            res_in.value   = changed ? data_ff[VAL_W-1:0] : old_ff;
            res_in.mark    = chg_ff[idx_a] | changed;
            res_in.enlist  = enl;
            res_in.pending = pending_ff | enl;
            pending_in     = pending_ff | enl;
            state_in       = changed ? S_WR1 : S_RSP;
         end

         // Pair: write the high word.
         S_WR1: begin
            ram_we    = 1'b1;
            ram_waddr = idx_b;
            ram_wdata = data_ff[DATA_W-1:VAL_W];
            state_in  = S_RSP;
         end

         S_RSP: begin
            out_valid = 1'b1;
            in_ready  = out_ready;
            if (out_ready) begin
               state_in = S_IDLE;
            end
         end

         // Dump walk: one entry a cycle while the result side takes words; a found entry is held
         // until the next one shows whether it is the final word.
         S_DCHK: begin
            out_valid = (rd_val != '0) && held_ff;
            if (!((rd_val != '0) && held_ff && !out_ready)) begin
               if (rd_val != '0) begin
                  res_in             = '0;
                  res_in.status      = ST_OK;
                  res_in.index       = IDX_W'(addr_ff);
                  res_in.value       = rd_val;
                  res_in.mark        = chg_ff[addr_ff];
                  res_in.pending     = pending_ff;
                  res_in.entry_valid = 1'b1;
                  res_in.byte_count  = res_ff.byte_count + ENTRY_BYTES;
                  held_in            = 1'b1;
               end
               if (last_addr) begin
                  state_in = S_RSP;
               end else begin
                  addr_in   = addr_ff + 1'b1;
                  ram_re    = 1'b1;
                  ram_raddr = addr_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Take a new request word.
      if (in_valid && in_ready) begin
         cmd_in         = in_cmd;
         idx_in         = in_idx;
         lane_in        = in_lane;
         data_in        = in_data;
         res_in         = '0;
         res_in.status  = ST_OK;
         res_in.pending = pending_ff;
         state_in       = S_RSP;
         case (in_cmd) inside
            CMD_DUMP: begin
               held_in = 1'b0;
               addr_in = '0;
               if (cnt != '0) begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  state_in  = S_DCHK;
               end
            end
            CMD_CLRM: begin
               chg_in         = '0;
               pending_in     = 1'b0;
               res_in.index   = in_idx;
               res_in.delist  = pending_ff & in_drop;
               res_in.pending = 1'b0;
            end
            [CMD_WORD:CMD_READ]: begin
               res_in.index = in_idx;
               if (idx_bad) begin
                  res_in.status = ST_BAD_INDEX;
               end else if (lane_bad) begin
                  res_in.status = ST_BAD_LANE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = in_idx[AW-1:0];
                  state_in  = S_RD0;
               end
            end
            default: begin
               res_in.pending = pending_ff;
            end
         endcase
      end

      // Every write marks its entry as written and changed.
      if (ram_we) begin
         valid_in[ram_waddr] = 1'b1;
         chg_in[ram_waddr]   = 1'b1;
      end
   end

   // The last flag is low only on dump entries sent during the walk.
   always_comb begin
      out_data      = res_ff;
      out_data.last = (state_ff != S_DCHK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pending_ff <= 1'b0;
         valid_ff   <= '0;
         chg_ff     <= '0;
         held_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
         chg_ff     <= chg_in;
         held_ff    <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      lane_ff <= lane_in;
      data_ff <= data_in;
      old_ff  <= old_in;
      addr_ff <= addr_in;
   end

   // A read and a write never meet on the same entry in one cycle.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("read and write of the same entry in one cycle");

   // The pending flag rises only out of a write step.
   a_pending_from_write: assert property (@(posedge clock) disable iff (reset)
      $rose(pending_ff) |-> ($past(state_ff == S_RD0) || $past(state_ff == S_RD1)))
      else $error("pending flag raised outside a write");

   // Words sent during the walk are real nonzero entries.
   a_dump_entry: assert property (@(posedge clock) disable iff (reset)
      (out_valid && (state_ff == S_DCHK)) |->
         (out_data.entry_valid && (out_data.value != '0)))
      else $error("dump sent an empty entry mid-walk");

   // A changed bit only exists on an entry that has been written.
   a_mark_written: assert property (@(posedge clock) disable iff (reset)
      (chg_ff & ~valid_ff) == '0)
      else $error("changed bit on an unwritten entry");

endmodule

`default_nettype wire

### src/dirty_tracked_field_store_core.sv
// Word, byte, half, flag and read commands read their field, write it if it changes, then
// answer; a pair reads both words and, when it changes the value, writes the low word, then
// the high word, before it answers; rejected, clear-marks and unknown commands answer with no
// memory access. The read-modify-write on the field memory holds off the next command until
// the result word is handed on; a dump holds the input for its walk plus result stalls.
// Reset is synchronous, active high: clears written/changed bits and pending, count 64, in_world 0.
`default_nettype none

module dirty_tracked_field_store_core
   import dtfs_pkg::*;
#(
   parameter int MAX_FIELDS = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Request stream.
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // [5:0] field_index, [8:6] lane_offset, [72:9] write_data, [73] drop_pending
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   // [3:0] command
   input  wire logic [CMD_W-1:0]       req_tuser,
   // Response stream.
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [5:0] result_index, [37:6] result_value, [38] changed_mark, [39] enlist,
   // [40] delist, [41] pending_now, [42] entry_valid, [51:43] byte_count
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   // [1:0] status
   output logic [ST_W-1:0]             rsp_tuser,
   output logic                        rsp_tlast,
   // Register write port.
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [0:0]             csr_index,
   input  wire logic [CNT_W-1:0]       csr_data
);

   localparam int AW = $clog2(MAX_FIELDS);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             world_ff, world_in;
   logic [CNT_W-1:0] eff_cnt;

   logic             seq_valid, seq_ready;
   rsp_type          seq_data, out_data;

   logic             ram_we, ram_re;
   logic [AW-1:0]    ram_waddr, ram_raddr;
   logic [VAL_W-1:0] ram_wdata, ram_rdata;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      count_in = count_ff;
      world_in = world_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIELDS_IN_USE: count_in = csr_data;
            CSR_IN_WORLD:      world_in = csr_data[0];
            default:           count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= FIELDS_RESET;
         world_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         world_ff <= world_in;
      end
   end

   // Field count saturates at the table depth.
   assign eff_cnt = (count_ff > CNT_W'(MAX_FIELDS)) ? CNT_W'(MAX_FIELDS) : count_ff;

   dtfs_seq #(
      .MAX_FIELDS (MAX_FIELDS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cnt       (eff_cnt),
      .in_world  (world_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_idx    (req_tdata[5:0]),
      .in_lane   (req_tdata[8:6]),
      .in_data   (req_tdata[72:9]),
      .in_drop   (req_tdata[73]),
      .out_valid (seq_valid),
      .out_ready (seq_ready),
      .out_data  (seq_data),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   dtfs_ram #(
      .WIDTH (VAL_W),
      .DEPTH (MAX_FIELDS)
   ) u_field_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   dtfs_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (seq_valid),
      .in_ready  (seq_ready),
      .in_data   (seq_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   // Pack the response word.
   assign rsp_tdata = {4'b0000, out_data.byte_count, out_data.entry_valid, out_data.pending,
                       out_data.delist, out_data.enlist, out_data.mark, out_data.value,
                       out_data.index};
   assign rsp_tuser = out_data.status;
   assign rsp_tlast = out_data.last;

endmodule

`default_nettype wire

### sim/dirty_tracked_field_store_core_tb.sv
`default_nettype none

module dirty_tracked_field_store_core_tb;
   import dtfs_pkg::*;

   // Clock, reset and block ports.
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   wire logic              req_tready;
   // [5:0] field_index, [8:6] lane_offset, [72:9] write_data, [73] drop_pending
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // [3:0] command
   logic [CMD_W-1:0]       req_tuser  = '0;
   wire logic              rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [5:0] result_index, [37:6] result_value, [38] changed_mark, [39] enlist,
   // [40] delist, [41] pending_now, [42] entry_valid, [51:43] byte_count
   wire logic [RSP_TDATA_W-1:0] rsp_tdata;
   // [1:0] status
   wire logic [ST_W-1:0]   rsp_tuser;
   wire logic              rsp_tlast;
   logic                   csr_valid  = 1'b0;
   wire logic              csr_ready;
   logic [0:0]             csr_index  = '0;
   logic [CNT_W-1:0]       csr_data   = '0;

   dirty_tracked_field_store_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Shadow copy of the field table, its marks and the register settings.
   logic [VAL_W-1:0] shadow_fields [64];
   logic [63:0]      shadow_changed = '0;
   logic             shadow_pending = 1'b0;
   logic [CNT_W-1:0] shadow_count   = FIELDS_RESET;
   logic             shadow_in_world = 1'b0;

   // Result words still to arrive, oldest first.
   rsp_type awaited_words [$];
   rsp_type seen_word;
   rsp_type want_word;
   int      errors = 0;
   bit      steady_flow = 1'b0;
   int      rsp_hold = 0;

   initial begin
      for (int i = 0; i < 64; i++) shadow_fields[i] = '0;
   end

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Apply one accepted command to the shadow table and queue its result words.
   function automatic void apply_store_command(input logic [CMD_W-1:0] cmd,
                                               input logic [IDX_W-1:0] idx,
                                               input logic [LANE_W-1:0] lane,
                                               input logic [DATA_W-1:0] data,
                                               input logic drop);
      rsp_type          r;
      int unsigned      cnt;
      int unsigned      total;
      logic [BC_W-1:0]  nent;
      logic [VAL_W-1:0] d32;
      logic [VAL_W-1:0] old_val;
      logic [VAL_W-1:0] new_val;
      logic             changed;
      int               i;
      r       = '0;
      cnt     = (shadow_count > 64) ? 64 : shadow_count;
      d32     = data[31:0];
      changed = 1'b0;
      total   = 0;
      nent    = '0;

      // A dump emits one word per nonzero field, or a single empty word.
      if (cmd == CMD_DUMP) begin
         for (i = 0; i < cnt; i++) if (shadow_fields[i] != '0) total++;
         if (total == 0) begin
            r.pending = shadow_pending;
            r.last    = 1'b1;
            awaited_words.push_back(r);
            return;
         end
         for (i = 0; i < cnt; i++) begin
            if (shadow_fields[i] != '0) begin
               nent          = nent + 1'b1;
               r             = '0;
               r.index       = i[IDX_W-1:0];
               r.value       = shadow_fields[i];
               r.mark        = shadow_changed[i];
               r.pending     = shadow_pending;
               r.entry_valid = 1'b1;
               r.byte_count  = nent * ENTRY_BYTES;
               r.last        = (nent == total);
               awaited_words.push_back(r);
            end
         end
         return;
      end

      if (cmd == CMD_CLRM) begin
         shadow_changed = '0;
         r.delist       = shadow_pending & drop;
         shadow_pending = 1'b0;
         r.index        = idx;
      end else if (cmd > CMD_DUMP) begin
         // Unknown commands leave the table alone.
         r = '0;
      end else begin
         r.index = idx;
         if ((cmd == CMD_PAIR) ? (int'(idx) + 1 >= cnt) : (int'(idx) >= cnt)) begin
            r.status = ST_BAD_INDEX;
         end else if ((cmd == CMD_BYTE && lane > 3) || (cmd == CMD_HALF && lane > 1)) begin
            r.status = ST_BAD_LANE;
         end else begin
            old_val = shadow_fields[idx];
            case (cmd)
               CMD_WORD: new_val = d32;
               CMD_BYTE: new_val = (old_val & ~(32'hFF << (int'(lane) * 8)))
                                   | ({24'b0, data[7:0]} << (int'(lane) * 8));
               CMD_HALF: new_val = (old_val & ~(32'hFFFF << (int'(lane) * 16)))
                                   | ({16'b0, data[15:0]} << (int'(lane) * 16));
               CMD_SETF: new_val = old_val | d32;
               CMD_CLRF: new_val = old_val & ~d32;
               default:  new_val = old_val;
            endcase
            if (cmd == CMD_PAIR) begin
               if (old_val != d32 || shadow_fields[int'(idx) + 1] != data[63:32]) begin
                  shadow_fields[idx]             = d32;
                  shadow_fields[int'(idx) + 1]   = data[63:32];
                  shadow_changed[idx]            = 1'b1;
                  shadow_changed[int'(idx) + 1]  = 1'b1;
                  changed                        = 1'b1;
               end
            end else if (new_val != old_val) begin
               shadow_fields[idx]  = new_val;
               shadow_changed[idx] = 1'b1;
               changed             = 1'b1;
            end
            // The first change of a live object enlists it.
            if (changed && shadow_in_world && !shadow_pending) begin
               shadow_pending = 1'b1;
               r.enlist       = 1'b1;
            end
            r.value = shadow_fields[idx];
            r.mark  = shadow_changed[idx];
         end
      end
      r.pending = shadow_pending;
      r.last    = 1'b1;
      awaited_words.push_back(r);
   endfunction

   // Offer one command word, wait for it to be taken, then predict it.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                               input logic [LANE_W-1:0] lane, input logic [DATA_W-1:0] data,
                               input logic drop);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {6'b0, drop, data, lane, idx};
      do @(posedge clock); while (!req_tready);
      apply_store_command(cmd, idx, lane, data, drop);
   endtask

   // Stop sending and wait until every awaited word has come in.
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // Hold one register write until it is taken; the caller drops the valid.
   task automatic write_csr(input logic [0:0] index, input logic [CNT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (index == CSR_FIELDS_IN_USE) shadow_count = value;
      else shadow_in_world = value[0];
   endtask

   task automatic set_config(input logic [CNT_W-1:0] count, input logic world);
      drain_block();
      write_csr(CSR_FIELDS_IN_USE, count);
      write_csr(CSR_IN_WORLD, {{(CNT_W-1){1'b0}}, world});
      csr_valid <= 1'b0;
   endtask

   // Empty table: dump, read of the top entry and an unknown command.
   task automatic test_reset_state();
      send_command(CMD_DUMP, 6'd0, 3'd0, 64'd0, 1'b0);
      send_command(CMD_READ, 6'd63, 3'd7, {64{1'b1}}, 1'b1);
      send_command(4'd15, 6'd63, 3'd7, {64{1'b1}}, 1'b1);
   endtask

   // Every write kind, bad lanes, enlist and delist on a live object.
   task automatic test_write_commands();
      set_config(7'd64, 1'b1);
      send_command(CMD_WORD, 6'd0, 3'd0, {64{1'b1}}, 1'b0);
      send_command(CMD_WORD, 6'd0, 3'd0, 64'h0000_0000_FFFF_FFFF, 1'b0);
      send_command(CMD_BYTE, 6'd1, 3'd3, 64'hFFFF_FFFF_FFFF_FFAB, 1'b0);
      send_command(CMD_HALF, 6'd2, 3'd1, 64'h1234_5678_9ABC_BEEF, 1'b0);
      send_command(CMD_PAIR, 6'd62, 3'd0, 64'hDEAD_BEEF_0BAD_F00D, 1'b0);
      send_command(CMD_PAIR, 6'd63, 3'd0, 64'h1111_2222_3333_4444, 1'b0);
      send_command(CMD_SETF, 6'd3, 3'd0, 64'h0000_0000_A5A5_A5A5, 1'b0);
      send_command(CMD_CLRF, 6'd3, 3'd0, 64'h0000_0000_FFFF_FFFF, 1'b0);
      send_command(CMD_BYTE, 6'd4, 3'd4, 64'h55, 1'b0);
      send_command(CMD_BYTE, 6'd4, 3'd7, 64'h55, 1'b0);
      send_command(CMD_HALF, 6'd5, 3'd2, 64'h55, 1'b0);
      send_command(CMD_HALF, 6'd5, 3'd7, 64'h55, 1'b0);
      send_command(CMD_READ, 6'd0, 3'd0, 64'd0, 1'b0);
      send_command(CMD_DUMP, 6'd0, 3'd0, 64'd0, 1'b0);
      send_command(CMD_CLRM, 6'd9, 3'd0, 64'd0, 1'b1);
      send_command(CMD_CLRM, 6'd9, 3'd0, 64'd0, 1'b0);
      send_command(CMD_WORD, 6'd7, 3'd0, 64'h77, 1'b0);
      send_command(CMD_CLRM, 6'd0, 3'd0, 64'd0, 1'b0);
   endtask

   // Count of zero, one and beyond the table size; index check wins over lane.
   task automatic test_count_limits();
      set_config(7'd0, 1'b1);
      send_command(CMD_WORD, 6'd0, 3'd0, 64'h1, 1'b0);
      send_command(CMD_DUMP, 6'd0, 3'd0, 64'd0, 1'b0);
      set_config(7'd1, 1'b0);
      send_command(CMD_PAIR, 6'd0, 3'd0, 64'h5, 1'b0);
      send_command(CMD_WORD, 6'd0, 3'd0, 64'h8000_0001, 1'b0);
      send_command(CMD_BYTE, 6'd1, 3'd5, 64'h1, 1'b0);
      send_command(CMD_DUMP, 6'd0, 3'd0, 64'd0, 1'b0);
      set_config(7'd127, 1'b0);
      send_command(CMD_WORD, 6'd63, 3'd0, 64'h3F, 1'b0);
      send_command(CMD_DUMP, 6'd0, 3'd0, 64'd0, 1'b0);
   endtask

   // Random commands: mostly in-range indexes and lanes with varied data.
   task automatic test_random_traffic(input int count);
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  idx;
      logic [LANE_W-1:0] lane;
      logic [DATA_W-1:0] data;
      int unsigned       cnt;
      int                r;
      for (int n = 0; n < count; n++) begin
         cnt = (shadow_count > 64) ? 64 : shadow_count;
         r   = $urandom_range(0, 99);
         if (r < 14)      cmd = CMD_WORD;
         else if (r < 24) cmd = CMD_PAIR;
         else if (r < 36) cmd = CMD_BYTE;
         else if (r < 48) cmd = CMD_HALF;
         else if (r < 58) cmd = CMD_SETF;
         else if (r < 68) cmd = CMD_CLRF;
         else if (r < 78) cmd = CMD_READ;
         else if (r < 85) cmd = CMD_CLRM;
         else if (r < 92) cmd = CMD_DUMP;
         else             cmd = CMD_W'($urandom_range(int'(CMD_DUMP) + 1, 15));

         if (cmd == CMD_PAIR && cnt >= 2 && $urandom_range(0, 99) < 85)
            idx = IDX_W'($urandom_range(0, cnt - 2));
         else if (cmd != CMD_PAIR && cnt >= 1 && $urandom_range(0, 99) < 85)
            idx = IDX_W'($urandom_range(0, cnt - 1));
         else
            idx = IDX_W'($urandom_range(0, 63));

         if (cmd == CMD_BYTE && $urandom_range(0, 99) < 85)      lane = LANE_W'($urandom_range(0, 3));
         else if (cmd == CMD_HALF && $urandom_range(0, 99) < 85) lane = LANE_W'($urandom_range(0, 1));
         else                                                   lane = LANE_W'($urandom_range(0, 7));

         // Zeros, unchanged values and small values keep dumps and marks varied.
         r = $urandom_range(0, 99);
         if (r < 12)      data = '0;
         else if (r < 27) data = {shadow_fields[(int'(idx) + 1) % 64], shadow_fields[idx]};
         else if (r < 40) data = {$urandom(), 24'b0, 8'($urandom_range(0, 255))};
         else if (r < 46) data = {64{1'b1}};
         else             data = {$urandom(), $urandom()};

         send_command(cmd, idx, lane, data, 1'($urandom_range(0, 1)));
      end
   endtask

   // Result side: random stalls unless the flow is steady.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (steady_flow || $urandom_range(0, 1)) begin
         rsp_tready <= 1'b1;
         rsp_hold   <= steady_flow ? 0 : $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b0;
         rsp_hold   <= pick_gap();
      end
   end

   // Compare each accepted result word with the oldest awaited one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_word.status      = rsp_tuser;
         seen_word.index       = rsp_tdata[5:0];
         seen_word.value       = rsp_tdata[37:6];
         seen_word.mark        = rsp_tdata[38];
         seen_word.enlist      = rsp_tdata[39];
         seen_word.delist      = rsp_tdata[40];
         seen_word.pending     = rsp_tdata[41];
         seen_word.entry_valid = rsp_tdata[42];
         seen_word.byte_count  = rsp_tdata[51:43];
         seen_word.last        = rsp_tlast;
         if (awaited_words.size() == 0) begin
            $display("%0t: unexpected result word tdata=%h tuser=%0d tlast=%b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want_word = awaited_words.pop_front();
            if (seen_word !== want_word) begin
               $display("%0t: expected st=%0d idx=%0d val=%h m=%b e=%b d=%b p=%b v=%b bc=%0d l=%b",
                        $time,
                        want_word.status, want_word.index, want_word.value, want_word.mark,
                        want_word.enlist, want_word.delist, want_word.pending,
                        want_word.entry_valid, want_word.byte_count, want_word.last);
               $display("%0t: actual   st=%0d idx=%0d val=%h m=%b e=%b d=%b p=%b v=%b bc=%0d l=%b",
                        $time,
                        seen_word.status, seen_word.index, seen_word.value, seen_word.mark,
                        seen_word.enlist, seen_word.delist, seen_word.pending,
                        seen_word.entry_valid, seen_word.byte_count, seen_word.last);
               errors++;
            end
         end
      end
   end

   // Overall time limit.
   initial begin
      #(200000000);
      $display("dirty_tracked_field_store_core: mismatch");
      $finish;
   end

   // Test sequence.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_write_commands();
      test_count_limits();
      set_config(7'd64, 1'b1);
      test_random_traffic(110);
      set_config(7'd7, 1'b1);
      steady_flow = 1'b1;
      test_random_traffic(50);
      steady_flow = 1'b0;
      test_random_traffic(50);
      set_config(7'd127, 1'b0);
      test_random_traffic(90);
      set_config(7'd2, 1'b1);
      test_random_traffic(60);
      set_config(7'd0, 1'b1);
      test_random_traffic(15);
      set_config(7'd33, 1'b1);
      test_random_traffic(40);
      drain_block();
      if (errors == 0) begin
         $display("dirty_tracked_field_store_core: match");
      end else begin
         $display("dirty_tracked_field_store_core: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
